/* design/gpm_pkg.sv */
package gpm_pkg;

  // Index widths sized for the largest supported pattern (64 bytes).
  localparam int GPM_AW = 7;
  localparam int GPM_EW = 6;

  // Element kinds held in each cell.
  localparam logic [2:0] K_LIT  = 3'd0;
  localparam logic [2:0] K_ANY  = 3'd1;
  localparam logic [2:0] K_STAR = 3'd2;
  localparam logic [2:0] K_SET  = 3'd3;
  localparam logic [2:0] K_DEAD = 3'd4;

  // Pattern syntax characters.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  // Write bus from the decoder to the cell row.
  typedef struct packed {
    logic              clr;
    logic              el_we;
    logic [GPM_AW-1:0] el_addr;
    logic              el_end;
    logic [2:0]        el_kind;
    logic [7:0]        el_arg;
    logic              ln_we;
    logic [GPM_AW-1:0] ln_addr;
    logic [GPM_EW-1:0] ln_src;
    logic              mb_we;
    logic [GPM_AW-1:0] mb_addr;
    logic              mb_range;
    logic              mb_open;
    logic [GPM_EW-1:0] mb_owner;
  } gpm_wr_t;

  // Decoded view of one pattern offset.
  typedef struct packed {
    logic              start;
    logic              is_end;
    logic [2:0]        kind;
    logic [7:0]        arg;
    logic              pv;
    logic [GPM_EW-1:0] pidx;
    logic              mem;
    logic              mrange;
    logic              mopen;
    logic [GPM_EW-1:0] owner;
  } gpm_cell_t;

endpackage

/* design/gpm_if.sv */
interface gpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface gpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic done_res;
  logic hopeless;
  modport source (output valid, output matched, output done_res, output hopeless, input ready);
  modport sink (input valid, input matched, input done_res, input hopeless, output ready);
endinterface

/* design/gpm_decoder.sv */
module gpm_decoder import gpm_pkg::*; #(
  parameter int PATTERN_BYTES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic [PATTERN_BYTES*8-1:0] pat_i,
  output gpm_wr_t                    wr_o,
  output logic                       busy_o,
  output logic                       has_dead_o
);

  localparam logic [2:0] ST_ELEM = 3'd0;
  localparam logic [2:0] ST_STAR = 3'd1;
  localparam logic [2:0] ST_SET0 = 3'd2;
  localparam logic [2:0] ST_SETM = 3'd3;
  localparam logic [2:0] ST_DEAD = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;
  localparam logic [2:0] ST_IDLE = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [GPM_AW-1:0] p_q, p_d;
  logic [GPM_EW-1:0] e_q, e_d;
  logic              neg_q, neg_d;
  logic              dead_q, dead_d;

  logic [PATTERN_BYTES*8+23:0] pad;
  logic [PATTERN_BYTES*8+23:0] win;
  logic [7:0] b0, b1, b2;

  // Three-byte window at the scan pointer; bytes past the end read as zero.
  assign pad = {24'd0, pat_i};
  assign win = pad >> {p_q, 3'b000};
  assign b0  = win[7:0];
  assign b1  = win[15:8];
  assign b2  = win[23:16];

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    e_d     = e_q;
    neg_d   = neg_q;
    dead_d  = dead_q;
    wr_o    = '0;
    wr_o.el_addr = p_q;
    wr_o.mb_addr = p_q;
    wr_o.mb_owner = e_q;
    wr_o.ln_src  = e_q;
    case (state_q)
      ST_CLR: begin
        wr_o.clr = 1'b1;
        p_d      = '0;
        dead_d   = 1'b0;
        state_d  = ST_ELEM;
      end
      ST_ELEM: begin
        wr_o.el_we = 1'b1;
        if (b0 == 8'd0) begin
          wr_o.el_end  = 1'b1;
          wr_o.el_kind = K_DEAD;
          state_d      = ST_IDLE;
        end else begin
          e_d         = p_q[GPM_EW-1:0];
          wr_o.ln_src = p_q[GPM_EW-1:0];
          if (b0 == CH_STAR || b0 == CH_COLON) begin
            wr_o.el_kind = K_STAR;
            wr_o.el_arg  = b0;
            p_d          = p_q + 1'b1;
            state_d      = ST_STAR;
          end else if (b0 == CH_QMARK) begin
            wr_o.el_kind = K_ANY;
            wr_o.ln_we   = 1'b1;
            wr_o.ln_addr = p_q + 1'b1;
            p_d          = p_q + 1'b1;
          end else if (b0 == CH_BSLASH) begin
            wr_o.el_kind = K_LIT;
            wr_o.ln_we   = 1'b1;
            if (b1 != 8'd0) begin
              wr_o.el_arg  = b1;
              wr_o.ln_addr = p_q + 2'd2;
              p_d          = p_q + 2'd2;
            end else begin
              wr_o.el_arg  = CH_BSLASH;
              wr_o.ln_addr = p_q + 1'b1;
              p_d          = p_q + 1'b1;
            end
          end else if (b0 == CH_LBRACK) begin
            // Provisionally dead; rewritten as a set once the close is found.
            wr_o.el_kind = K_DEAD;
            neg_d        = 1'b0;
            p_d          = p_q + 1'b1;
            state_d      = ST_SET0;
          end else begin
            wr_o.el_kind = K_LIT;
            wr_o.el_arg  = b0;
            wr_o.ln_we   = 1'b1;
            wr_o.ln_addr = p_q + 1'b1;
            p_d          = p_q + 1'b1;
          end
        end
      end
      ST_STAR: begin
        if (b0 == CH_STAR || b0 == CH_COLON) begin
          p_d = p_q + 1'b1;
        end else begin
          wr_o.ln_we   = 1'b1;
          wr_o.ln_addr = p_q;
          state_d      = ST_ELEM;
        end
      end
      ST_SET0: begin
        if (b0 == CH_CARET) begin
          neg_d = 1'b1;
          p_d   = p_q + 1'b1;
        end
        state_d = ST_SETM;
      end
      ST_SETM: begin
        wr_o.el_addr = {1'b0, e_q};
        wr_o.el_kind = K_SET;
        wr_o.el_arg  = {7'd0, neg_q};
        if (b0 == 8'd0) begin
          dead_d  = 1'b1;
          state_d = ST_DEAD;
        end else begin
          wr_o.mb_we = 1'b1;
          if (b1 == 8'd0) begin
            dead_d  = 1'b1;
            state_d = ST_DEAD;
          end else if (b1 == CH_RBRACK) begin
            wr_o.el_we   = 1'b1;
            wr_o.ln_we   = 1'b1;
            wr_o.ln_addr = p_q + 2'd2;
            p_d          = p_q + 2'd2;
            state_d      = ST_ELEM;
          end else if (b1 == CH_DASH) begin
            if (b2 == 8'd0) begin
              dead_d  = 1'b1;
              state_d = ST_DEAD;
            end else if (b2 == CH_RBRACK) begin
              wr_o.mb_open = 1'b1;
              wr_o.el_we   = 1'b1;
              wr_o.ln_we   = 1'b1;
              wr_o.ln_addr = p_q + 2'd3;
              p_d          = p_q + 2'd3;
              state_d      = ST_ELEM;
            end else begin
              wr_o.mb_range = 1'b1;
              p_d           = p_q + 2'd2;
            end
          end else begin
            p_d = p_q + 1'b1;
          end
        end
      end
      ST_DEAD: begin
        // Only the end offset is still needed.
        if (b0 == 8'd0) begin
          wr_o.el_we   = 1'b1;
          wr_o.el_end  = 1'b1;
          wr_o.el_kind = K_DEAD;
          state_d      = ST_IDLE;
        end else begin
          p_d = p_q + 1'b1;
        end
      end
      ST_IDLE: begin
      end
      default: begin
        state_d = ST_CLR;
      end
    endcase
    if (restart_i) begin
      state_d = ST_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ELEM;
      p_q     <= '0;
      e_q     <= '0;
      neg_q   <= 1'b0;
      dead_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      e_q     <= e_d;
      neg_q   <= neg_d;
      dead_q  <= dead_d;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign has_dead_o = dead_q;

endmodule

/* design/gpm_cell.sv */
module gpm_cell import gpm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gpm_wr_t   wr_i,
  input  logic [7:0] lo_i,
  input  logic [7:0] hi_i,
  input  logic [7:0] ch_i,
  input  logic      live_we_i,
  input  logic      live_d_i,
  output gpm_cell_t cfg_o,
  output logic      live_o,
  output logic      hit_o
);

  localparam logic [GPM_AW-1:0] MY_ADDR = GPM_AW'(IDX);

  gpm_cell_t cfg_q;
  logic      live_q;
  logic signed [7:0] sa, sz, sc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_i.clr) begin
      cfg_q <= '0;
    end else begin
      if (wr_i.el_we && wr_i.el_addr == MY_ADDR) begin
        cfg_q.start  <= 1'b1;
        cfg_q.is_end <= wr_i.el_end;
        cfg_q.kind   <= wr_i.el_kind;
        cfg_q.arg    <= wr_i.el_arg;
      end
      if (wr_i.ln_we && wr_i.ln_addr == MY_ADDR) begin
        cfg_q.pv   <= 1'b1;
        cfg_q.pidx <= wr_i.ln_src;
      end
      if (wr_i.mb_we && wr_i.mb_addr == MY_ADDR) begin
        cfg_q.mem    <= 1'b1;
        cfg_q.mrange <= wr_i.mb_range;
        cfg_q.mopen  <= wr_i.mb_open;
        cfg_q.owner  <= wr_i.mb_owner;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= (IDX == 0);
    end else if (live_we_i) begin
      live_q <= live_d_i;
    end
  end

  // Set member test; bytes compare as signed values.
  assign sa = lo_i;
  assign sz = hi_i;
  assign sc = ch_i;

  always_comb begin
    if (!cfg_q.mem) begin
      hit_o = 1'b0;
    end else if (cfg_q.mopen) begin
      hit_o = (sc >= sa);
    end else if (cfg_q.mrange) begin
      hit_o = (sc == sa) || (sc == sz) || ((sc > sa) && (sc < sz));
    end else begin
      hit_o = (sc == sa);
    end
  end

  assign cfg_o  = cfg_q;
  assign live_o = live_q;

endmodule

/* design/glob_pattern_matcher_unit.sv */
// Streaming glob matcher.
// The pattern is loaded through the write port (cfg_we_i, cfg_idx_i,
// cfg_data_i): register 0..7 holds pattern bytes 8*i..8*i+7, lowest first.
// After each write, a decoder walks the pattern offset by offset and loads the
// cell row; in_if.ready stays low meanwhile. Reset clears the pattern and
// runs the same short decode of the empty pattern.
// Subject bytes enter on in_if, one word per cycle while the decoder is idle
// and the output is not stalled; each word yields one registered result word
// on out_if: matched, done_res (the byte was the terminator 0, matched is the
// verdict) and hopeless. A terminator restarts matching from the pattern start.
// Each cell holds one pattern offset and its live bit; all cells advance on
// every accepted byte, so throughput is one byte per cycle when not stalled.
// A single output register parts the channels: when the receiver stalls,
// the result holds and the input is taken again only as the result leaves.
module glob_pattern_matcher_unit import gpm_pkg::*; #(
  parameter int PATTERN_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gpm_in_if.sink      in_if,
  gpm_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int NPOS = PATTERN_BYTES + 1;

  logic [PATTERN_BYTES*8-1:0] pat_q;
  logic [PATTERN_BYTES*8+23:0] pat_pad;
  gpm_wr_t   wr;
  logic      busy, has_dead;
  gpm_cell_t cfg [NPOS];
  logic [NPOS-1:0] live, hit, cur, nxt, cur2, live_d;
  logic [63:0] star_lv, star2, cons;
  logic [PATTERN_BYTES-1:0] set_ok;
  logic [7:0] ch;
  logic accept, term, sep, m_d, h_d;
  logic out_valid_q, matched_q, done_q, hop_q;

  // Pattern registers; bytes past the pattern size are dropped.
  for (genvar b = 0; b < PATTERN_BYTES; b++) begin : g_pat
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pat_q[b*8 +: 8] <= 8'd0;
      end else if (cfg_we_i && cfg_idx_i == 4'(b / 8)) begin
        pat_q[b*8 +: 8] <= cfg_data_i[(b % 8)*8 +: 8];
      end
    end
  end

  assign pat_pad = {24'd0, pat_q};

  gpm_decoder #(.PATTERN_BYTES(PATTERN_BYTES)) u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .pat_i     (pat_q),
    .wr_o      (wr),
    .busy_o    (busy),
    .has_dead_o(has_dead)
  );

  assign ch     = in_if.ch;
  assign in_if.ready = !busy && (!out_valid_q || out_if.ready);
  assign accept = in_if.valid && in_if.ready;
  assign term   = (ch == 8'd0);
  assign sep    = (ch == CH_SLASH) || (ch == CH_BSLASH);

  for (genvar k = 0; k < NPOS; k++) begin : g_cell
    gpm_cell #(.IDX(k)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (wr),
      .lo_i     (pat_pad[k*8 +: 8]),
      .hi_i     (pat_pad[(k+2)*8 +: 8]),
      .ch_i     (ch),
      .live_we_i(accept),
      .live_d_i (live_d[k]),
      .cfg_o    (cfg[k]),
      .live_o   (live[k]),
      .hit_o    (hit[k])
    );
  end

  always_comb begin
    star_lv = '0;
    star2   = '0;
    cons    = '0;
    set_ok  = '0;
    // Live star elements also enable the element after their run.
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      star_lv[i] = live[i] && cfg[i].start && (cfg[i].kind == K_STAR);
    end
    for (int j = 0; j < NPOS; j++) begin
      cur[j] = (live[j] && cfg[j].start) || (cfg[j].pv && star_lv[cfg[j].pidx]);
    end
    // Gather set member hits per owning element.
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      for (int k = 0; k < PATTERN_BYTES; k++) begin
        if (hit[k] && cfg[k].owner == GPM_EW'(i)) begin
          set_ok[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      if (cur[i] && cfg[i].start) begin
        case (cfg[i].kind)
          K_LIT:   cons[i] = (cfg[i].arg == ch);
          K_ANY:   cons[i] = 1'b1;
          K_SET:   cons[i] = set_ok[i] ^ cfg[i].arg[0];
          default: cons[i] = 1'b0;
        endcase
      end
    end
    for (int j = 0; j < NPOS; j++) begin
      nxt[j] = (cfg[j].start && cfg[j].kind == K_STAR && cur[j] &&
                (cfg[j].arg == CH_STAR || !sep)) ||
               (cfg[j].pv && cons[cfg[j].pidx]);
    end
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      star2[i] = nxt[i] && cfg[i].start && (cfg[i].kind == K_STAR);
    end
    for (int j = 0; j < NPOS; j++) begin
      cur2[j] = (nxt[j] && cfg[j].start) || (cfg[j].pv && star2[cfg[j].pidx]);
    end
    m_d = 1'b0;
    for (int j = 0; j < NPOS; j++) begin
      if (term) begin
        m_d = m_d | (cur[j] && cfg[j].is_end);
      end else begin
        m_d = m_d | (cur2[j] && cfg[j].is_end);
      end
    end
    h_d = term ? !m_d : (has_dead || !(|cur2));
    // A terminator restarts from the pattern start.
    for (int j = 0; j < NPOS; j++) begin
      live_d[j] = term ? (j == 0) : nxt[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      matched_q <= m_d;
      done_q    <= term;
      hop_q     <= h_d;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.matched  = matched_q;
  assign out_if.done_res = done_q;
  assign out_if.hopeless = hop_q;

endmodule

/* design/gpm_checker.sv */
module gpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_ch,
  input logic       out_valid,
  input logic       out_ready,
  input logic       matched,
  input logic       done_res,
  input logic       hopeless
);

  // A terminator word produces a final verdict in the next cycle.
  a_term_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_ch == 8'd0 |=> out_valid && done_res)
    else $error("terminator did not give a final verdict");

  a_byte_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_ch != 8'd0 |=> out_valid && !done_res)
    else $error("subject byte gave no running status");

  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && done_res |-> matched != hopeless)
    else $error("verdict and hopeless disagree");

  a_match_hope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && matched |-> !hopeless)
    else $error("matching subject flagged hopeless");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind glob_pattern_matcher_unit gpm_checker u_gpm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .in_ch    (in_if.ch),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .matched  (out_if.matched),
  .done_res (out_if.done_res),
  .hopeless (out_if.hopeless)
);
